// File: hdl/csemtw_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore package
// Shared constants, payload structs and control types of the semaphore block.
// ----------------------------------------------------------------------------
package csemtw_pkg;

   localparam int MAX_WAITERS = 16;
   localparam int IDX_W       = $clog2(MAX_WAITERS);
   localparam int CNT_W       = $clog2(MAX_WAITERS + 1);

   localparam logic signed [15:0] INIT_COUNT_RESET = 16'sd1;

   localparam logic [1:0] KIND_WAIT   = 2'd0;
   localparam logic [1:0] KIND_SIGNAL = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic [2:0] EV_GRANTED  = 3'd0;
   localparam logic [2:0] EV_BLOCKED  = 3'd1;
   localparam logic [2:0] EV_WOKEN    = 3'd2;
   localparam logic [2:0] EV_TIMEOUT  = 3'd3;
   localparam logic [2:0] EV_SIG_DONE = 3'd4;
   localparam logic [2:0] EV_FULL     = 3'd5;
   localparam logic [2:0] EV_REJECTED = 3'd6;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         task_id;
      logic [15:0]        wait_time;
      logic signed [15:0] permits;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] out_task;
      logic [4:0] freed_count;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      TL_NOP,
      TL_DEC,
      TL_POP,
      TL_POP_MERGE,
      TL_START,
      TL_STEP
   } tl_op_type;

   typedef struct packed {
      tl_op_type   op;
      logic [7:0]  task_id;
      logic [15:0] wait_time;
   } tl_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] size;
      logic             full;
      logic             head_zero;
      logic             next_zero;
      logic [7:0]       head_task;
      logic             ins_done;
   } tl_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INSERT,
      ST_SIGNAL,
      ST_TICK
   } state_type;

endpackage

// File: hdl/csemtw_fifo.sv
// ----------------------------------------------------------------------------
// Semaphore wait FIFO
// Circular queue of tasks blocked without a time limit.
// ----------------------------------------------------------------------------
module csemtw_fifo
   import csemtw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [7:0]       push_task,
   input  logic             pop,
   output logic [7:0]       head_task,
   output logic [CNT_W-1:0] size,
   output logic             full
);

   logic [7:0]       task_ff [MAX_WAITERS];
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [CNT_W:0]   tail_sum;
   logic [IDX_W-1:0] tail_idx;

   // Tail position, wrapped without a divider.
   always_comb begin
      tail_sum = {1'b0, CNT_W'(head_ff)} + {1'b0, size_ff};
      if (tail_sum >= (CNT_W+1)'(MAX_WAITERS)) begin
         tail_idx = IDX_W'(tail_sum - (CNT_W+1)'(MAX_WAITERS));
      end else begin
         tail_idx = IDX_W'(tail_sum);
      end
   end

   always_comb begin
      head_in = head_ff;
      size_in = size_ff;
      if (push) begin
         size_in = size_ff + 1'b1;
      end else if (pop) begin
         size_in = size_ff - 1'b1;
         if (head_ff == IDX_W'(MAX_WAITERS - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         size_ff <= '0;
      end else begin
         head_ff <= head_in;
         size_ff <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         task_ff[tail_idx] <= push_task;
      end
   end

   assign head_task = task_ff[head_ff];
   assign size      = size_ff;
   assign full      = (size_ff == CNT_W'(MAX_WAITERS));

endmodule

// File: hdl/csemtw_tlist.sv
// ----------------------------------------------------------------------------
// Semaphore timeout list
// Delta-ordered list of timed waiters.
// ----------------------------------------------------------------------------
module csemtw_tlist
   import csemtw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tl_cmd_type  cmd,
   output tl_stat_type stat
);

   logic [7:0]       task_ff  [MAX_WAITERS];
   logic [7:0]       task_in  [MAX_WAITERS];
   logic [15:0]      delta_ff [MAX_WAITERS];
   logic [15:0]      delta_in [MAX_WAITERS];
   logic [CNT_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [15:0]      w_ff, w_in;
   logic [7:0]       ins_task_ff, ins_task_in;
   logic [15:0]      cur_d;
   logic             at_end;
   logic             d_gt;
   logic             ins_done;
   logic [15:0]      diff_dw;
   logic [15:0]      diff_wd;
   logic [16:0]      merge_sum;

   // The walk compares the remaining wait against one entry per cycle.
   always_comb begin
      cur_d     = delta_ff[pos_ff[IDX_W-1:0]];
      at_end    = (pos_ff == size_ff);
      d_gt      = (cur_d > w_ff);
      ins_done  = at_end || d_gt;
      diff_dw   = cur_d - w_ff;
      diff_wd   = w_ff - cur_d;
      merge_sum = {1'b0, delta_ff[0]} + {1'b0, delta_ff[1]};
   end

   always_comb begin
      task_in     = task_ff;
      delta_in    = delta_ff;
      size_in     = size_ff;
      pos_in      = pos_ff;
      w_in        = w_ff;
      ins_task_in = ins_task_ff;
      case (cmd.op)
         TL_DEC: begin
            if (delta_ff[0] != 16'd0) begin
               delta_in[0] = delta_ff[0] - 1'b1;
            end
         end
         TL_POP, TL_POP_MERGE: begin
            for (int i = 0; i < MAX_WAITERS - 1; i++) begin
               task_in[i]  = task_ff[i+1];
               delta_in[i] = delta_ff[i+1];
            end
            // The successor inherits what was left of the released head.
            if (cmd.op == TL_POP_MERGE) begin
               delta_in[0] = merge_sum[16] ? 16'hFFFF : merge_sum[15:0];
            end
            size_in = size_ff - 1'b1;
         end
         TL_START: begin
            pos_in      = '0;
            w_in        = cmd.wait_time;
            ins_task_in = cmd.task_id;
         end
         TL_STEP: begin
            if (ins_done) begin
               for (int i = 1; i < MAX_WAITERS; i++) begin
                  if (CNT_W'(i) > pos_ff) begin
                     task_in[i] = task_ff[i-1];
                     if (CNT_W'(i - 1) == pos_ff) begin
                        delta_in[i] = diff_dw;
                     end else begin
                        delta_in[i] = delta_ff[i-1];
                     end
                  end
               end
               for (int i = 0; i < MAX_WAITERS; i++) begin
                  if (CNT_W'(i) == pos_ff) begin
                     task_in[i]  = ins_task_ff;
                     delta_in[i] = w_ff;
                  end
               end
               size_in = size_ff + 1'b1;
            end else begin
               w_in   = diff_wd;
               pos_in = pos_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else begin
         size_ff <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff     <= task_in;
      delta_ff    <= delta_in;
      pos_ff      <= pos_in;
      w_ff        <= w_in;
      ins_task_ff <= ins_task_in;
   end

   always_comb begin
      stat.size      = size_ff;
      stat.full      = (size_ff == CNT_W'(MAX_WAITERS));
      stat.head_zero = (size_ff != '0) && (delta_ff[0] == 16'd0);
      stat.next_zero = (size_ff > CNT_W'(1)) && (delta_ff[1] == 16'd0);
      stat.head_task = task_ff[0];
      stat.ins_done  = ins_done;
   end

endmodule

// File: hdl/counting_semaphore_timed_wait.sv
// ----------------------------------------------------------------------------
// Counting semaphore with timed waits
// Task semaphore with a FIFO of unlimited waiters and a delta timeout list.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req_ channel (valid/stall), one transfer per
// operation: a wait, a signal or one timer tick. Each request gives zero or
// more results on the rsp_ channel, and the final one carries last.
// The block takes a request only while idle; it then decodes it and issues
// its results one at a time. A wait that goes into the timeout list walks
// the list one entry per cycle. A signal gives one result per released task
// plus the done result; a tick one result per timed-out task. Results leave
// through one output register; while the receiver holds a result the
// sequencer waits for the slot, though the walk of the timeout list still
// steps up to its final step. A synchronous reset empties both queues and
// loads the count with one; a csr_ write loads the count at once.
// ----------------------------------------------------------------------------
module counting_semaphore_timed_wait
   import csemtw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload,
   input  logic               csr_wr_en,
   input  logic signed [15:0] csr_wr_data
);

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic signed [15:0] count_ff, count_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic [CNT_W-1:0]   freed_ff, freed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               slot_free;
   logic               emit;
   rsp_type            emit_data;
   logic               fifo_push;
   logic               fifo_pop;
   logic [7:0]         fifo_head_task;
   logic [CNT_W-1:0]   fifo_size;
   logic               fifo_full;
   tl_cmd_type         tl_cmd;
   tl_stat_type        tl_stat;
   logic [16:0]        count_sum;
   logic [15:0]        perm_eff;

   csemtw_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_task (item_ff.task_id),
      .pop       (fifo_pop),
      .head_task (fifo_head_task),
      .size      (fifo_size),
      .full      (fifo_full)
   );

   csemtw_tlist u_tlist (
      .clock (clock),
      .reset (reset),
      .cmd   (tl_cmd),
      .stat  (tl_stat)
   );

   // A result may be loaded when the output register is empty or drains now.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // A permit count of zero counts as one; the sum saturates at the top.
   always_comb begin
      perm_eff  = (item_ff.permits == 16'sd0) ? 16'd1 : item_ff.permits;
      count_sum = {count_ff[15], count_ff} + {1'b0, perm_eff};
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      count_in  = count_ff;
      limit_in  = limit_ff;
      freed_in  = freed_ff;
      emit      = 1'b0;
      emit_data = '0;
      fifo_push = 1'b0;
      fifo_pop  = 1'b0;
      tl_cmd    = '{op: TL_NOP, task_id: item_ff.task_id, wait_time: item_ff.wait_time};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               case (item_ff.kind)
                  KIND_WAIT: begin
                     emit                = 1'b1;
                     emit_data.out_task  = item_ff.task_id;
                     emit_data.last      = 1'b1;
                     state_in            = ST_IDLE;
                     if (count_ff > 16'sd0) begin
                        count_in            = count_ff - 16'sd1;
                        emit_data.event_res = EV_GRANTED;
                     end else if ((item_ff.wait_time == 16'd0) ? fifo_full
                                                                : tl_stat.full) begin
                        emit_data.event_res = EV_FULL;
                     end else begin
                        if (count_ff != -16'sd32768) begin
                           count_in = count_ff - 16'sd1;
                        end
                        emit_data.event_res = EV_BLOCKED;
                        if (item_ff.wait_time == 16'd0) begin
                           fifo_push = 1'b1;
                        end else begin
                           // The blocked result waits for the end of the walk.
                           emit      = 1'b0;
                           tl_cmd.op = TL_START;
                           state_in  = ST_INSERT;
                        end
                     end
                  end
                  KIND_SIGNAL: begin
                     if (item_ff.permits < 16'sd0) begin
                        emit                = 1'b1;
                        emit_data.event_res = EV_REJECTED;
                        emit_data.last      = 1'b1;
                        state_in            = ST_IDLE;
                     end else begin
                        if (count_sum[16:15] == 2'b01) begin
                           count_in = 16'sd32767;
                        end else begin
                           count_in = count_sum[15:0];
                        end
                        if (perm_eff >= 16'(MAX_WAITERS)) begin
                           limit_in = CNT_W'(MAX_WAITERS);
                        end else begin
                           limit_in = CNT_W'(perm_eff);
                        end
                        freed_in = '0;
                        state_in = ST_SIGNAL;
                     end
                  end
                  KIND_TICK: begin
                     if (tl_stat.size == '0) begin
                        state_in = ST_IDLE;
                     end else begin
                        tl_cmd.op = TL_DEC;
                        state_in  = ST_TICK;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INSERT: begin
            // The final step inserts the entry and reports at the same time.
            if (!tl_stat.ins_done || slot_free) begin
               tl_cmd.op = TL_STEP;
            end
            if (tl_stat.ins_done && slot_free) begin
               emit                = 1'b1;
               emit_data.event_res = EV_BLOCKED;
               emit_data.out_task  = item_ff.task_id;
               emit_data.last      = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_SIGNAL: begin
            if (slot_free) begin
               emit = 1'b1;
               if ((freed_ff < limit_ff) && (fifo_size != '0)) begin
                  emit_data.event_res = EV_WOKEN;
                  emit_data.out_task  = fifo_head_task;
                  fifo_pop            = 1'b1;
                  freed_in            = freed_ff + 1'b1;
               end else if ((freed_ff < limit_ff) && (tl_stat.size != '0)) begin
                  emit_data.event_res = EV_WOKEN;
                  emit_data.out_task  = tl_stat.head_task;
                  tl_cmd.op           = TL_POP_MERGE;
                  freed_in            = freed_ff + 1'b1;
               end else begin
                  emit_data.event_res   = EV_SIG_DONE;
                  emit_data.freed_count = 5'(freed_ff);
                  emit_data.last        = 1'b1;
                  state_in              = ST_IDLE;
               end
            end
         end
         ST_TICK: begin
            if (!tl_stat.head_zero) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               emit                = 1'b1;
               emit_data.event_res = EV_TIMEOUT;
               emit_data.out_task  = tl_stat.head_task;
               emit_data.last      = !tl_stat.next_zero;
               tl_cmd.op           = TL_POP;
               if (!tl_stat.next_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= INIT_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      limit_ff <= limit_in;
      freed_ff <= freed_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A result that is not the final one means the request is still in work.
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> req_stall)
      else $error("request accepted before the final result");

   // A signal never reports more than MAX_WAITERS releases.
   a_freed_bound: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_data.event_res == EV_SIG_DONE) |->
         (emit_data.freed_count <= 5'(MAX_WAITERS)))
      else $error("signal released too many tasks");

   // Neither queue ever grows beyond its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (fifo_size <= CNT_W'(MAX_WAITERS)) && (tl_stat.size <= CNT_W'(MAX_WAITERS)))
      else $error("queue size out of range");

   // A task is pushed into the wait FIFO only while it has room.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_full)
      else $error("push into a full wait queue");

endmodule

// File: test/tb_counting_semaphore_timed_wait.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Counting semaphore testbench
// Drives waits, signals and timer ticks with random idling on both sides.
// A scoreboard class predicts every result and checks the results in order.
// ----------------------------------------------------------------------------

import csemtw_pkg::*;

// Scoreboard: holds a private copy of the semaphore state and a queue of the
// results that are still owed by the block.
class sem_scoreboard;
   int          count;
   logic [7:0]  fifo_q[$];
   logic [7:0]  timed_id[$];
   int          timed_dly[$];
   rsp_type     owed[$];
   int          errors;

   function void load_count(logic signed [15:0] value);
      count = value;
   endfunction

   function void clear();
      count = 1;
      fifo_q.delete();
      timed_id.delete();
      timed_dly.delete();
      owed.delete();
      errors = 0;
   endfunction

   function void push(logic [2:0] ev, logic [7:0] id, logic [4:0] freed, logic lst);
      rsp_type r;
      r.event_res   = ev;
      r.out_task    = id;
      r.freed_count = freed;
      r.last        = lst;
      owed.push_back(r);
   endfunction

   function void put_timed(logic [7:0] id, int w);
      int pos;
      pos = 0;
      while (pos < timed_dly.size()) begin
         if (timed_dly[pos] > w) begin
            timed_dly[pos] = timed_dly[pos] - w;
            break;
         end
         w   = w - timed_dly[pos];
         pos = pos + 1;
      end
      timed_id.insert(pos, id);
      timed_dly.insert(pos, w);
   endfunction

   // Note one accepted request and queue what it should produce.
   function void note_request(req_type rq);
      int p, lim, freed, d, s, n;
      case (rq.kind)
         KIND_WAIT: begin
            if (count > 0) begin
               count--;
               push(EV_GRANTED, rq.task_id, 0, 1);
            end else if ((rq.wait_time == 0 && fifo_q.size() >= MAX_WAITERS) ||
                         (rq.wait_time != 0 && timed_id.size() >= MAX_WAITERS)) begin
               push(EV_FULL, rq.task_id, 0, 1);
            end else begin
               if (count > -32768) count--;
               if (rq.wait_time == 0) fifo_q.push_back(rq.task_id);
               else put_timed(rq.task_id, rq.wait_time);
               push(EV_BLOCKED, rq.task_id, 0, 1);
            end
         end
         KIND_SIGNAL: begin
            if (rq.permits < 0) begin
               push(EV_REJECTED, 0, 0, 1);
            end else begin
               p = (rq.permits == 0) ? 1 : int'(rq.permits);
               count = count + p;
               if (count > 32767) count = 32767;
               lim = (p < MAX_WAITERS) ? p : MAX_WAITERS;
               freed = 0;
               while (freed < lim) begin
                  if (fifo_q.size() > 0) begin
                     push(EV_WOKEN, fifo_q.pop_front(), 0, 0);
                  end else if (timed_id.size() > 0) begin
                     d = timed_dly.pop_front();
                     push(EV_WOKEN, timed_id.pop_front(), 0, 0);
                     // The successor inherits the released head's remaining delay.
                     if (timed_dly.size() > 0) begin
                        s = timed_dly[0] + d;
                        timed_dly[0] = (s > 65535) ? 65535 : s;
                     end
                  end else begin
                     break;
                  end
                  freed++;
               end
               push(EV_SIG_DONE, 0, freed[4:0], 1);
            end
         end
         KIND_TICK: begin
            if (timed_id.size() > 0) begin
               if (timed_dly[0] > 0) timed_dly[0] = timed_dly[0] - 1;
               n = 0;
               while (timed_id.size() > 0 && timed_dly[0] == 0 && n < MAX_WAITERS) begin
                  void'(timed_dly.pop_front());
                  push(EV_TIMEOUT, timed_id.pop_front(), 0, 0);
                  n++;
               end
               if (n > 0) owed[owed.size() - 1].last = 1;
            end
         end
         default: ;
      endcase
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (owed.size() == 0) begin
         $display("%0t: unexpected result %p", $time, got);
         errors++;
         return;
      end
      want = owed.pop_front();
      if (got.event_res !== want.event_res) begin
         $display("%0t: event_res expected %0d actual %0d", $time, want.event_res,
                  got.event_res);
         errors++;
      end
      if (got.out_task !== want.out_task) begin
         $display("%0t: out_task expected %0d actual %0d", $time, want.out_task,
                  got.out_task);
         errors++;
      end
      if (got.freed_count !== want.freed_count) begin
         $display("%0t: freed_count expected %0d actual %0d", $time,
                  want.freed_count, got.freed_count);
         errors++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
         errors++;
      end
   endfunction
endclass

module tb_counting_semaphore_timed_wait;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_wr_en = 1'b0;
   logic signed [15:0] csr_wr_data = '0;

   sem_scoreboard sb = new();

   // Idling control. The quiet window switches random idling off on both
   // sides; the hold window makes the receiver stall for a long stretch.
   bit quiet_window = 1'b0;
   bit hold_window  = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   counting_semaphore_timed_wait u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Receiver: stalls at random about 16 percent of the time. Results are
   // checked at the edge where the transfer happens, using the values that
   // stood before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      if (hold_window) rsp_stall <= 1'b1;
      else if (quiet_window) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 16);
   end

   // Long receiver hold-off, counted in cycles in its own process.
   task automatic hold_receiver(int cycles);
      hold_window = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_window = 1'b0;
   endtask

   // Offer one request and wait for its transfer. An idle gap may come first.
   // Valid stays high from one request to the next when there is no gap.
   task automatic send(req_type rq);
      if (!quiet_window && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (req_stall);
      sb.note_request(rq);
   endtask

   task automatic send_fields(logic [1:0] kind, logic [7:0] id, logic [15:0] wt,
                              logic signed [15:0] perm);
      req_type rq;
      rq.kind      = kind;
      rq.task_id   = id;
      rq.wait_time = wt;
      rq.permits   = perm;
      send(rq);
   endtask

   // Let the block drain completely, then wait out any trailing work.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Write the count register while the block is idle.
   task automatic load_count(logic signed [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.load_count(value);
   endtask

   // Random request biased toward waits that block, small delays and ticks,
   // so that both queues fill up and release often.
   task automatic send_random();
      req_type rq;
      int      sel;
      sel = $urandom_range(99);
      rq.task_id = $urandom();
      rq.permits = '0;
      rq.wait_time = '0;
      if (sel < 45) begin
         rq.kind = KIND_WAIT;
         case ($urandom_range(3))
            0: rq.wait_time = 0;
            1: rq.wait_time = $urandom();
            default: rq.wait_time = $urandom_range(6, 1);
         endcase
         rq.permits = $urandom();
      end else if (sel < 70) begin
         rq.kind = KIND_SIGNAL;
         case ($urandom_range(5))
            0: rq.permits = $urandom();
            1: rq.permits = $urandom_range(40, 17);
            default: rq.permits = $urandom_range(3);
         endcase
         rq.wait_time = $urandom();
      end else if (sel < 97) begin
         rq.kind = KIND_TICK;
      end else begin
         rq.kind = 2'd3;
      end
      send(rq);
   endtask

   initial begin
      int i;
      sb.clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset count of one.
      send_fields(KIND_WAIT,   8'h00, 16'd0,     16'sd0);      // granted
      send_fields(KIND_WAIT,   8'hff, 16'd0,     16'sd0);      // blocked, unlimited
      send_fields(KIND_WAIT,   8'h11, 16'd3,     16'sd0);      // timed
      send_fields(KIND_WAIT,   8'h22, 16'd1,     16'sd0);      // goes in front
      send_fields(KIND_WAIT,   8'h33, 16'hffff,  16'sd0);      // longest delay
      send_fields(KIND_SIGNAL, 8'h00, 16'd0,     16'sh8000);   // rejected
      send_fields(KIND_SIGNAL, 8'h00, 16'd0,     16'sd0);      // zero acts as one
      send_fields(KIND_SIGNAL, 8'h00, 16'd0,     16'sd1);      // releases a timed head
      send_fields(KIND_TICK,   8'h00, 16'd0,     16'sd0);
      send_fields(KIND_TICK,   8'h00, 16'd0,     16'sd0);
      send_fields(2'd3,        8'haa, 16'h5555,  16'sh5555);   // unused kind
      send_fields(KIND_SIGNAL, 8'h00, 16'hffff,  16'sh7fff);   // releases all timed waiters
      send_fields(KIND_TICK,   8'h00, 16'd0,     16'sd0);      // empty list
      drain();

      // Fill both queues from the lowest count, then overflow them.
      load_count(16'sh8000);
      for (i = 0; i < 17; i++) send_fields(KIND_WAIT, i[7:0], 16'd0, 16'sd0);
      for (i = 0; i < 17; i++) send_fields(KIND_WAIT, 8'h80 + i[7:0], 16'd2, 16'sd0);
      send_fields(KIND_TICK, 8'h00, 16'd0, 16'sd0);
      send_fields(KIND_TICK, 8'h00, 16'd0, 16'sd0);  // all sixteen time out at once
      send_fields(KIND_SIGNAL, 8'h00, 16'd0, 16'sd40);
      drain();

      // Random phases at several counts; the first one carries the long
      // receiver hold-off while the sender keeps offering requests.
      load_count(16'sd0);
      fork
         hold_receiver(300);
         for (i = 0; i < 50; i++) send_random();
      join
      drain();

      load_count(16'sh7fff);
      for (i = 0; i < 20; i++) send_random();
      drain();

      load_count(16'sd2);
      quiet_window = 1'b1;
      for (i = 0; i < 30; i++) send_random();
      quiet_window = 1'b0;
      for (i = 0; i < 20; i++) send_random();
      drain();

      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("tb_counting_semaphore_timed_wait: done, clean");
      end else begin
         $display("tb_counting_semaphore_timed_wait: done, errors");
      end
      $finish;
   end

   // Hard limit on the run length.
   initial begin
      #4000000;
      $display("tb_counting_semaphore_timed_wait: done, errors");
      $finish;
   end

endmodule

// File: sim.f
hdl/csemtw_pkg.sv
hdl/csemtw_fifo.sv
hdl/csemtw_tlist.sv
hdl/counting_semaphore_timed_wait.sv
test/tb_counting_semaphore_timed_wait.sv
